/* rtl/core/pct_pkg.sv */
// Package: shared constants, codes, payload structs and controller types.
package pct_pkg;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned AGENTS       = 64;
  localparam int unsigned PAYLOAD_BITS = 32;

  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned AG_IDX_W = $clog2(AGENTS);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;

  localparam logic [1:0] CLS_CARD = 2'd0;
  localparam logic [1:0] CLS_NON  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  conflict_class;
    logic [5:0]  agent_a;
    logic [5:0]  agent_b;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  best_class;
    logic [5:0]  best_agent_a;
    logic [5:0]  best_agent_b;
    logic [31:0] best_payload;
    logic [6:0]  total_count;
    logic [6:0]  cardinal_count;
    logic [5:0]  matching_count;
    logic [6:0]  pair_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]              cls;
    logic [5:0]              a;
    logic [5:0]              b;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_ENT,
    S_SCAN_PAIR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic ins_wr;
    logic rm_step;
    logic clr_step;
    logic scan_start;
    logic scan_rd;
    logic scan_ent;
    logic scan_pair;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic rm_done;
    logic clr_last;
    logic scan_done;
  } sts_t;

endpackage

/* rtl/core/pct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pct_ctrl.sv */
// Controller: request sequencing state machine.
module pct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [1:0]    req_type_i,
  input  pct_pkg::sts_t sts_i,
  output pct_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  pct_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pct_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pct_pkg::S_IDLE: begin
        if (start) begin
          if (req_type_i == pct_pkg::REQ_INSERT) begin
            state_d = pct_pkg::S_INSERT;
          end else if (req_type_i == pct_pkg::REQ_REMOVE) begin
            state_d = pct_pkg::S_REMOVE;
          end else begin
            state_d = pct_pkg::S_CLEAR;
          end
        end
      end
      pct_pkg::S_INSERT: state_d = pct_pkg::S_CLEAR;
      pct_pkg::S_REMOVE: begin
        if (sts_i.rm_done) state_d = pct_pkg::S_CLEAR;
      end
      pct_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = pct_pkg::S_SCAN_RD;
      end
      pct_pkg::S_SCAN_RD: begin
        state_d = sts_i.scan_done ? pct_pkg::S_DONE : pct_pkg::S_SCAN_ENT;
      end
      pct_pkg::S_SCAN_ENT:  state_d = pct_pkg::S_SCAN_PAIR;
      pct_pkg::S_SCAN_PAIR: state_d = pct_pkg::S_SCAN_RD;
      pct_pkg::S_DONE:      state_d = pct_pkg::S_IDLE;
      default:              state_d = pct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      pct_pkg::S_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start;
      end
      pct_pkg::S_INSERT: cmd_o.ins_wr  = 1'b1;
      pct_pkg::S_REMOVE: cmd_o.rm_step = 1'b1;
      pct_pkg::S_CLEAR: begin
        cmd_o.clr_step   = 1'b1;
        cmd_o.scan_start = sts_i.clr_last;
      end
      pct_pkg::S_SCAN_RD:   cmd_o.scan_rd   = !sts_i.scan_done;
      pct_pkg::S_SCAN_ENT:  cmd_o.scan_ent  = 1'b1;
      pct_pkg::S_SCAN_PAIR: cmd_o.scan_pair = 1'b1;
      pct_pkg::S_DONE:      cmd_o.finish    = 1'b1;
      default:              busy_o          = 1'b1;
    endcase
  end

endmodule

/* rtl/core/pct_dp.sv */
// Datapath: conflict table, pair bitmap, scan accumulators, result register.
module pct_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pct_pkg::cmd_t cmd_i,
  input  pct_pkg::req_t req_i,
  output pct_pkg::sts_t sts_o,
  output pct_pkg::rsp_t rsp_o,
  output logic          valid_o
);

  pct_pkg::req_t   req_q, req_in;
  pct_pkg::entry_t best_q, best_d;
  pct_pkg::entry_t ent_rd, ent_wd, new_ent;
  pct_pkg::rsp_t   rsp_q, rsp_d;

  logic [pct_pkg::CNT_W-1:0]    cnt_q, rd_q, wr_q;
  logic                         pend_q, full_q, best_vld_q, valid_q;
  logic [6:0]                   card_q, pair_q;
  logic [5:0]                   match_q;
  logic [pct_pkg::AGENTS-1:0]   used_q, used_d;
  logic [pct_pkg::AG_IDX_W-1:0] clr_q, lo_q, hi_q, lo_d, hi_d;
  logic [pct_pkg::AGENTS-1:0]   bm_rd, bm_wd;
  logic                         ent_we, ent_re, bm_we, keep, is_full, rd_end;
  logic [pct_pkg::IDX_W-1:0]    ent_waddr;
  logic [pct_pkg::AG_IDX_W-1:0] bm_waddr;
  logic [1:0]                   cls_in;

  assign is_full = (cnt_q == pct_pkg::CNT_W'(pct_pkg::CAPACITY));
  assign rd_end  = (rd_q == cnt_q);
  assign keep    = (ent_rd.a != req_q.agent_a) && (ent_rd.b != req_q.agent_a);

  assign cls_in          = (req_i.conflict_class > pct_pkg::CLS_NON) ? pct_pkg::CLS_NON
                                                                     : req_i.conflict_class;
  always_comb begin
    req_in                = req_i;
    req_in.conflict_class = cls_in;
  end

  assign new_ent.cls     = req_q.conflict_class;
  assign new_ent.a       = req_q.agent_a;
  assign new_ent.b       = req_q.agent_b;
  assign new_ent.pay     = pct_pkg::PAYLOAD_BITS'(req_q.payload);

  assign ent_we    = (cmd_i.ins_wr && !is_full) || (cmd_i.rm_step && pend_q && keep);
  assign ent_waddr = cmd_i.ins_wr ? cnt_q[pct_pkg::IDX_W-1:0] : wr_q[pct_pkg::IDX_W-1:0];
  assign ent_wd    = cmd_i.ins_wr ? new_ent : ent_rd;
  assign ent_re    = (cmd_i.rm_step && !rd_end) || cmd_i.scan_rd;

  pct_ram #(
    .WIDTH (pct_pkg::ENTRY_W),
    .DEPTH (pct_pkg::CAPACITY)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wd),
    .re_i    (ent_re),
    .raddr_i (rd_q[pct_pkg::IDX_W-1:0]),
    .rdata_o (ent_rd)
  );

  // normalized pair: row = lower agent, bit = higher agent
  assign lo_d = (ent_rd.a > ent_rd.b) ? ent_rd.b : ent_rd.a;
  assign hi_d = (ent_rd.a > ent_rd.b) ? ent_rd.a : ent_rd.b;

  assign bm_we    = cmd_i.clr_step || cmd_i.scan_pair;
  assign bm_waddr = cmd_i.clr_step ? clr_q : lo_q;
  assign bm_wd    = cmd_i.clr_step ? '0
                                   : (bm_rd | (pct_pkg::AGENTS'(1) << hi_q));

  pct_ram #(
    .WIDTH (pct_pkg::AGENTS),
    .DEPTH (pct_pkg::AGENTS)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wd),
    .re_i    (cmd_i.scan_ent),
    .raddr_i (lo_d),
    .rdata_o (bm_rd)
  );

  assign sts_o.rm_done   = rd_end && !pend_q;
  assign sts_o.clr_last  = (clr_q == pct_pkg::AG_IDX_W'(pct_pkg::AGENTS - 1));
  assign sts_o.scan_done = rd_end;

  assign best_d = ent_rd;

  // both agents of a chosen cardinal conflict become used
  assign used_d = used_q | (pct_pkg::AGENTS'(1) << ent_rd.a)
                         | (pct_pkg::AGENTS'(1) << ent_rd.b);

  always_comb begin
    rsp_d                = '0;
    rsp_d.total_count    = 7'(cnt_q);
    rsp_d.cardinal_count = card_q;
    rsp_d.matching_count = match_q;
    rsp_d.pair_count     = pair_q;
    if (!best_vld_q) begin
      rsp_d.status = pct_pkg::ST_EMPTY;
    end else begin
      rsp_d.status       = full_q ? pct_pkg::ST_FULL : pct_pkg::ST_OK;
      rsp_d.best_class   = best_q.cls;
      rsp_d.best_agent_a = best_q.a;
      rsp_d.best_agent_b = best_q.b;
      rsp_d.best_payload = 32'(best_q.pay);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      pend_q     <= 1'b0;
      full_q     <= 1'b0;
      best_vld_q <= 1'b0;
      valid_q    <= 1'b0;
      card_q     <= '0;
      pair_q     <= '0;
      match_q    <= '0;
      used_q     <= '0;
      clr_q      <= '0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cmd_i.latch) begin
        rd_q   <= '0;
        wr_q   <= '0;
        pend_q <= 1'b0;
        full_q <= 1'b0;
        clr_q  <= '0;
        used_q <= '0;
      end
      if (cmd_i.ins_wr) begin
        if (is_full) full_q <= 1'b1;
        else         cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.rm_step) begin
        pend_q <= !rd_end;
        if (!rd_end) rd_q <= rd_q + 1'b1;
        if (pend_q && keep) wr_q <= wr_q + 1'b1;
        if (rd_end && !pend_q) cnt_q <= wr_q;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.scan_start) begin
        rd_q       <= '0;
        best_vld_q <= 1'b0;
        card_q     <= '0;
        pair_q     <= '0;
        match_q    <= '0;
      end
      if (cmd_i.scan_ent) begin
        if (ent_rd.cls == pct_pkg::CLS_CARD) begin
          card_q <= card_q + 1'b1;
          if (!used_q[ent_rd.a] && !used_q[ent_rd.b]) begin
            match_q <= match_q + 1'b1;
            used_q  <= used_d;
          end
        end
        if (!best_vld_q || (ent_rd.cls < best_q.cls)) best_vld_q <= 1'b1;
      end
      if (cmd_i.scan_pair) begin
        rd_q <= rd_q + 1'b1;
        if (!bm_rd[hi_q]) pair_q <= pair_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_in;
    end
    if (cmd_i.scan_ent) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      if (!best_vld_q || (ent_rd.cls < best_q.cls)) best_q <= best_d;
    end
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  assign rsp_o   = rsp_q;
  assign valid_o = valid_q;

endmodule

/* rtl/core/prioritized_conflict_table.sv */
// Top level: prioritized conflict table (controller plus datapath).
//
// Usage: hold a request on req_i and raise start while busy is low; the
// request transfers at that clock edge. Kinds: insert appends a conflict
// (dropped with status full when the table holds its capacity), remove
// deletes every conflict naming agent_a keeping the order of the rest,
// any other kind is a query. Every request yields exactly one result on
// rsp_o, marked by result_valid_o for one cycle; the result transfers at
// the edge that ends that cycle and the receiver cannot hold it off.
// The result describes the table after the request: the oldest conflict
// of the lowest class, total and cardinal counts, greedy matching size
// over cardinal conflicts and the number of distinct unordered pairs.
// Each request runs a row-by-row clear of the pair bitmap RAM and then
// a scan of the entry RAM, each entry taking an entry read, a bitmap
// read and a bitmap write; an insert first writes its entry, and a
// remove first runs a compaction pass over the entries it started with.
// One request is in work at a time; busy drops in the strobe cycle, so
// the next request may transfer there. Reset empties the table; RAM
// contents need no reset.
module prioritized_conflict_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pct_pkg::req_t req_i,
  output pct_pkg::rsp_t rsp_o,
  output logic          result_valid_o
);

  pct_pkg::cmd_t cmd;
  pct_pkg::sts_t sts;

  pct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  pct_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .sts_o   (sts),
    .rsp_o   (rsp_o),
    .valid_o (result_valid_o)
  );

endmodule

/* rtl/core/pct_checker.sv */
// Port-level checker for the conflict table, bound to the top level.
module pct_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input pct_pkg::rsp_t rsp_o,
  input logic          result_valid_o
);

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe repeated");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy missing after transfer");

  a_end_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o) else $error("request ended without result");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.status == pct_pkg::ST_EMPTY) |-> (rsp_o.total_count == 7'd0))
    else $error("empty status with entries");

  a_card_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.cardinal_count <= rsp_o.total_count))
    else $error("cardinal count exceeds total");

endmodule

bind prioritized_conflict_table pct_checker u_pct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .rsp_o          (rsp_o),
  .result_valid_o (result_valid_o)
);
